// ===== rtl/core/lprd_pkg.sv =====
// ----------------------------------------------------------------------------
// lprd_pkg
// Types and constants shared by the request deframer modules.
// ----------------------------------------------------------------------------
package lprd_pkg;

    localparam int CNT_W  = 16;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 16;
    localparam int ERR_W  = 3;

    localparam logic [CFG_W-1:0] MAX_BODY_LEN_RST  = CFG_W'(4096);
    localparam logic [CFG_W-1:0] MAX_ARG_COUNT_RST = CFG_W'(1024);
    localparam logic [CNT_W-1:0] MIN_BODY_LEN      = CNT_W'(4);

    // configuration register indexes
    localparam logic REG_MAX_BODY_LEN  = 1'b0;
    localparam logic REG_MAX_ARG_COUNT = 1'b1;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BODY_SHORT = 3'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_MANY   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVERRUN    = 3'd4;
    localparam logic [ERR_W-1:0] ERR_TRAILING   = 3'd5;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_NARG,
        PH_ALEN,
        PH_DATA,
        PH_DEAD
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ARG_BYTE,
        KIND_EMPTY_ARG,
        KIND_DONE,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        phase_t             phase;
        logic [1:0]         byte_of_word;
        logic [CNT_W-1:0]   acc;
        logic [CNT_W-1:0]   body_rem;
        logic [CNT_W-1:0]   args_rem;
        logic [CNT_W-1:0]   cur_arg;
        logic [CNT_W-1:0]   arg_bytes_rem;
        logic [CNT_W-1:0]   total_args;
    } state_t;

    localparam state_t STATE_CLEAR = '{
        phase:         PH_LEN,
        byte_of_word:  2'd0,
        acc:           '0,
        body_rem:      '0,
        args_rem:      '0,
        cur_arg:       '0,
        arg_bytes_rem: '0,
        total_args:    '0
    };

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  arg_byte;
        logic [CNT_W-1:0]   arg_index;
        logic               arg_end;
        logic [CNT_W-1:0]   arg_count;
        logic [ERR_W-1:0]   error_code;
        logic               last;
    } res_t;

    typedef struct packed {
        res_t       r0;
        res_t       r1;
        logic [1:0] count;
    } res_pair_t;

endpackage

// ===== rtl/core/lprd_parser.sv =====
// ----------------------------------------------------------------------------
// lprd_parser
// Parser state and the per-byte framing logic; up to two results per byte.
// ----------------------------------------------------------------------------
module lprd_parser
    import lprd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_new,
    input  logic [CFG_W-1:0]  max_body_len,
    input  logic [CFG_W-1:0]  max_arg_count,
    output res_pair_t         results
);

    state_t state_reg;
    state_t state_next;
    state_t cur;

    logic [1:0]       idx;
    logic [1:0]       ahead;
    logic             hi;
    logic [CNT_W-1:0] acc_new;
    logic [CNT_W-1:0] body_dec;
    logic [CNT_W-1:0] abr_dec;
    logic [CNT_W-1:0] left;
    logic             after;
    logic             fail;
    logic [ERR_W-1:0] fail_code;
    logic             prim_valid;
    res_t             prim;
    logic             sec_valid;
    res_t             sec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cur = in_new ? STATE_CLEAR : state_reg;
        state_next = cur;
        idx = cur.byte_of_word;
        ahead = 2'd3 - idx;
        // upper header bytes must be zero for any 16-bit limit to hold
        hi = idx[1] && (in_byte != '0);
        case (idx)
            2'd0:    acc_new = cur.acc | {8'h00, in_byte};
            2'd1:    acc_new = cur.acc | {in_byte, 8'h00};
            default: acc_new = cur.acc;
        endcase
        body_dec = (cur.body_rem != '0) ? cur.body_rem - 1'b1 : '0;
        abr_dec  = (cur.arg_bytes_rem != '0) ? cur.arg_bytes_rem - 1'b1 : '0;
        left = (body_dec >= {{(CNT_W-2){1'b0}}, ahead})
             ? body_dec - {{(CNT_W-2){1'b0}}, ahead} : '0;

        after = 1'b0;
        fail = 1'b0;
        fail_code = ERR_NONE;
        prim_valid = 1'b0;
        prim = '0;
        sec_valid = 1'b0;
        sec = '0;

        case (cur.phase)
            PH_LEN:
            begin
                if (hi || (acc_new > max_body_len))
                begin
                    fail = 1'b1;
                    fail_code = ERR_TOO_LONG;
                end
                else if (idx == 2'd3)
                begin
                    if (acc_new < MIN_BODY_LEN)
                    begin
                        fail = 1'b1;
                        fail_code = ERR_BODY_SHORT;
                    end
                    else
                    begin
                        state_next.body_rem = acc_new;
                        state_next.phase = PH_NARG;
                        state_next.byte_of_word = 2'd0;
                        state_next.acc = '0;
                    end
                end
                else
                begin
                    state_next.byte_of_word = idx + 2'd1;
                    state_next.acc = acc_new;
                end
            end
            PH_NARG:
            begin
                state_next.body_rem = body_dec;
                if (hi || (acc_new > max_arg_count))
                begin
                    fail = 1'b1;
                    fail_code = ERR_TOO_MANY;
                end
                else if (idx == 2'd3)
                begin
                    state_next.total_args = acc_new;
                    state_next.args_rem = acc_new;
                    state_next.cur_arg = '0;
                    after = 1'b1;
                end
                else
                begin
                    state_next.byte_of_word = idx + 2'd1;
                    state_next.acc = acc_new;
                end
            end
            PH_ALEN:
            begin
                state_next.body_rem = body_dec;
                if (hi || (acc_new > left))
                begin
                    fail = 1'b1;
                    fail_code = ERR_OVERRUN;
                end
                else if (idx == 2'd3)
                begin
                    state_next.arg_bytes_rem = acc_new;
                    if (acc_new == '0)
                    begin
                        prim_valid = 1'b1;
                        prim.kind = KIND_EMPTY_ARG;
                        prim.arg_index = cur.cur_arg;
                        state_next.cur_arg = cur.cur_arg + 1'b1;
                        state_next.args_rem = (cur.args_rem != '0)
                                            ? cur.args_rem - 1'b1 : '0;
                        after = 1'b1;
                    end
                    else
                    begin
                        state_next.phase = PH_DATA;
                    end
                end
                else
                begin
                    state_next.byte_of_word = idx + 2'd1;
                    state_next.acc = acc_new;
                end
            end
            PH_DATA:
            begin
                state_next.body_rem = body_dec;
                state_next.arg_bytes_rem = abr_dec;
                prim_valid = 1'b1;
                prim.kind = KIND_ARG_BYTE;
                prim.arg_byte = in_byte;
                prim.arg_index = cur.cur_arg;
                if (abr_dec == '0)
                begin
                    prim.arg_end = 1'b1;
                    state_next.cur_arg = cur.cur_arg + 1'b1;
                    state_next.args_rem = (cur.args_rem != '0)
                                        ? cur.args_rem - 1'b1 : '0;
                    after = 1'b1;
                end
            end
            default:
            begin
                state_next.phase = PH_DEAD;
            end
        endcase

        // argument count known or an argument finished
        if (after)
        begin
            if (state_next.args_rem == '0)
            begin
                if (state_next.body_rem != '0)
                begin
                    fail = 1'b1;
                    fail_code = ERR_TRAILING;
                end
                else
                begin
                    sec_valid = 1'b1;
                    sec.kind = KIND_DONE;
                    sec.arg_count = state_next.total_args;
                    state_next.phase = PH_LEN;
                    state_next.byte_of_word = 2'd0;
                    state_next.acc = '0;
                end
            end
            else if (state_next.body_rem < MIN_BODY_LEN)
            begin
                fail = 1'b1;
                fail_code = ERR_TRUNCATED;
            end
            else
            begin
                state_next.phase = PH_ALEN;
                state_next.byte_of_word = 2'd0;
                state_next.acc = '0;
            end
        end

        if (fail)
        begin
            state_next.phase = PH_DEAD;
            sec_valid = 1'b1;
            sec = '0;
            sec.kind = KIND_ERROR;
            sec.error_code = fail_code;
        end

        results = '0;
        if (prim_valid)
        begin
            results.r0 = prim;
            if (sec_valid)
            begin
                results.r1 = sec;
                results.r1.last = 1'b1;
                results.count = 2'd2;
            end
            else
            begin
                results.r0.last = 1'b1;
                results.count = 2'd1;
            end
        end
        else if (sec_valid)
        begin
            results.r0 = sec;
            results.r0.last = 1'b1;
            results.count = 2'd1;
        end
    end

endmodule

// ===== rtl/core/lprd_outq.sv =====
// ----------------------------------------------------------------------------
// lprd_outq
// Two-slot result register; drains one result per transfer.
// ----------------------------------------------------------------------------
module lprd_outq
    import lprd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  res_pair_t results,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output res_t      out_res
);

    res_t       slot0_reg;
    res_t       slot1_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_res   = slot0_reg;
    assign pop       = out_valid && out_ready;
    assign can_load  = (count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= results.count;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= results.r0;
            slot1_reg <= results.r1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

// ===== rtl/core/length_prefixed_request_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer
// Splits a length-prefixed request byte stream into argument byte, empty
// argument, request done and error results.
// Path: each byte is held in the input register, its results in the result
// register. Throughput: one byte per cycle when m_tready is high; after a byte
// with two results, the next byte waits while the result register drains.
// Reset: parser returns to waiting for a body length; limits take 4096/1024.
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer
    import lprd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] new_connection
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // arg_byte, arg_index, arg_end, arg_count,
                                         // error_code, zero pad
    output logic [1:0]        m_tuser,   // [1:0] kind
    output logic              m_tlast,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_new_reg;
    logic [CFG_W-1:0]  max_body_len_reg;
    logic [CFG_W-1:0]  max_arg_count_reg;
    logic              advance;
    logic              can_load;
    res_pair_t         results;
    res_t              out_res;

    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_new_reg  <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_len_reg  <= MAX_BODY_LEN_RST;
            max_arg_count_reg <= MAX_ARG_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_BODY_LEN:  max_body_len_reg  <= cfg_data;
                REG_MAX_ARG_COUNT: max_arg_count_reg <= cfg_data;
                default:           max_body_len_reg  <= max_body_len_reg;
            endcase
        end
    end

    lprd_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_byte       (in_byte_reg),
        .in_new        (in_new_reg),
        .max_body_len  (max_body_len_reg),
        .max_arg_count (max_arg_count_reg),
        .results       (results)
    );

    lprd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .results   (results),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {4'b0000, out_res.error_code, out_res.arg_count, out_res.arg_end,
                      out_res.arg_index, out_res.arg_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// ===== verif/length_prefixed_request_deframer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer_checker
// Watches the byte input, the result output and the register write port of
// the deframer. It keeps its own copy of the parser state and limits, predicts
// the results of every accepted byte and compares each result transfer, field
// by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer_checker
    import lprd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] data_byte
    input  logic             s_tuser,   // [0] new_connection
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [47:0]      m_tdata,   // [7:0] arg_byte, [23:8] arg_index, [24] arg_end,
                                        // [40:25] arg_count, [43:41] error_code, pad
    input  logic [1:0]       m_tuser,   // [1:0] kind
    input  logic             m_tlast,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               mismatches,
    output int               pending,
    output int               results_seen
);

    logic [CFG_W-1:0] body_limit;
    logic [CFG_W-1:0] argc_limit;

    phase_t           ph;
    logic [1:0]       word_byte;
    logic [31:0]      word;
    logic [CNT_W-1:0] body_left;
    logic [CNT_W-1:0] args_left;
    logic [CNT_W-1:0] arg_idx;
    logic [CNT_W-1:0] data_left;
    logic [CNT_W-1:0] argc;

    res_t byte_results[$];
    res_t expected_results[$];

    function automatic res_t make_result(kind_t k, logic [7:0] b, logic [CNT_W-1:0] idx,
                                         logic e, logic [CNT_W-1:0] cnt,
                                         logic [ERR_W-1:0] err);
        res_t r;
        r = '0;
        r.kind       = k;
        r.arg_byte   = b;
        r.arg_index  = idx;
        r.arg_end    = e;
        r.arg_count  = cnt;
        r.error_code = err;
        return r;
    endfunction

    function automatic string show(res_t r);
        return $sformatf("kind=%0d byte=%02h index=%0d end=%0b count=%0d err=%0d last=%0b",
                         r.kind, r.arg_byte, r.arg_index, r.arg_end, r.arg_count,
                         r.error_code, r.last);
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic reset_parser();
        ph        = PH_LEN;
        word_byte = 2'd0;
        word      = '0;
        body_left = '0;
        args_left = '0;
        arg_idx   = '0;
        data_left = '0;
        argc      = '0;
    endtask

    task automatic start_word(input phase_t next_ph);
        ph        = next_ph;
        word_byte = 2'd0;
        word      = '0;
    endtask

    task automatic raise_error(input logic [ERR_W-1:0] code);
        ph = PH_DEAD;
        byte_results = {byte_results,
                        make_result(KIND_ERROR, 8'd0, '0, 1'b0, '0, code)};
    endtask

    // argument count known or an argument just ended
    task automatic close_arg_list();
        if (args_left == 0)
        begin
            if (body_left != 0)
                raise_error(ERR_TRAILING);
            else
            begin
                byte_results = {byte_results,
                                make_result(KIND_DONE, 8'd0, '0, 1'b0, argc, ERR_NONE)};
                start_word(PH_LEN);
            end
        end
        else if (body_left < MIN_BODY_LEN)
            raise_error(ERR_TRUNCATED);
        else
            start_word(PH_ALEN);
    endtask

    task automatic finish_arg();
        arg_idx = arg_idx + 1'b1;
        if (args_left != 0)
            args_left = args_left - 1'b1;
        close_arg_list();
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fresh);
        logic [1:0]  idx;
        logic [31:0] ahead;
        logic [31:0] room;
        byte_results.delete();
        if (fresh)
            reset_parser();
        idx = word_byte;
        case (ph)
            PH_LEN:
            begin
                word = word | (32'(b) << (8 * int'(idx)));
                if (word > 32'(body_limit))
                    raise_error(ERR_TOO_LONG);
                else if (idx == 2'd3)
                begin
                    if (word < 32'(MIN_BODY_LEN))
                        raise_error(ERR_BODY_SHORT);
                    else
                    begin
                        body_left = word[CNT_W-1:0];
                        start_word(PH_NARG);
                    end
                end
                else
                    word_byte = idx + 2'd1;
            end
            PH_NARG:
            begin
                if (body_left != 0)
                    body_left = body_left - 1'b1;
                word = word | (32'(b) << (8 * int'(idx)));
                if (word > 32'(argc_limit))
                    raise_error(ERR_TOO_MANY);
                else if (idx == 2'd3)
                begin
                    argc      = word[CNT_W-1:0];
                    args_left = argc;
                    arg_idx   = '0;
                    close_arg_list();
                end
                else
                    word_byte = idx + 2'd1;
            end
            PH_ALEN:
            begin
                if (body_left != 0)
                    body_left = body_left - 1'b1;
                ahead = 32'd3 - 32'(idx);
                room  = (32'(body_left) >= ahead) ? 32'(body_left) - ahead : 32'd0;
                word  = word | (32'(b) << (8 * int'(idx)));
                if (word > room)
                    raise_error(ERR_OVERRUN);
                else if (idx == 2'd3)
                begin
                    data_left = word[CNT_W-1:0];
                    if (data_left == 0)
                    begin
                        byte_results = {byte_results,
                                        make_result(KIND_EMPTY_ARG, 8'd0, arg_idx,
                                                    1'b0, '0, ERR_NONE)};
                        finish_arg();
                    end
                    else
                        ph = PH_DATA;
                end
                else
                    word_byte = idx + 2'd1;
            end
            PH_DATA:
            begin
                if (body_left != 0)
                    body_left = body_left - 1'b1;
                if (data_left != 0)
                    data_left = data_left - 1'b1;
                if (data_left == 0)
                begin
                    byte_results = {byte_results,
                                    make_result(KIND_ARG_BYTE, b, arg_idx, 1'b1, '0,
                                                ERR_NONE)};
                    finish_arg();
                end
                else
                    byte_results = {byte_results,
                                    make_result(KIND_ARG_BYTE, b, arg_idx, 1'b0, '0,
                                                ERR_NONE)};
            end
            default:
                ph = PH_DEAD;
        endcase
        if (byte_results.size() != 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
        expected_results = {expected_results, byte_results};
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t actual;
        res_t want;
        if (!rst_n)
        begin
            body_limit = MAX_BODY_LEN_RST;
            argc_limit = MAX_ARG_COUNT_RST;
            reset_parser();
            expected_results.delete();
            mismatches   = 0;
            results_seen = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_BODY_LEN:  body_limit = cfg_data;
                    REG_MAX_ARG_COUNT: argc_limit = cfg_data;
                    default:           body_limit = body_limit;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                actual            = '0;
                actual.kind       = kind_t'(m_tuser);
                actual.arg_byte   = m_tdata[7:0];
                actual.arg_index  = m_tdata[23:8];
                actual.arg_end    = m_tdata[24];
                actual.arg_count  = m_tdata[40:25];
                actual.error_code = m_tdata[43:41];
                actual.last       = m_tlast;
                results_seen++;
                if (expected_results.size() == 0)
                    log_mismatch({"result with nothing expected: ", show(actual)});
                else
                begin
                    want = expected_results.pop_front();
                    if (actual.kind !== want.kind || actual.arg_byte !== want.arg_byte ||
                        actual.arg_index !== want.arg_index ||
                        actual.arg_end !== want.arg_end ||
                        actual.arg_count !== want.arg_count ||
                        actual.error_code !== want.error_code ||
                        actual.last !== want.last)
                        log_mismatch({"expected ", show(want), " got ", show(actual)});
                end
            end
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tuser);
            pending = expected_results.size();
        end
    end

endmodule

// ===== verif/length_prefixed_request_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer_tb
// Feeds the deframer with directed and random request streams under several
// body length and argument count limits, with random gaps on the input and
// random back-pressure on the output. Results are checked by the companion
// checker module.
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer_tb;
    import lprd_pkg::*;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'd0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [47:0]      m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int results_seen;

    int idle_pct   = 14;
    int bytes_sent = 0;
    int good_bytes = 0;
    int requests   = 0;
    int body_lim   = 4096;
    int args_lim   = 1024;
    logic need_fresh = 1'b0;

    logic [7:0] frame_q[$];
    int         arg_lens[$];

    length_prefixed_request_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    length_prefixed_request_deframer_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= idle_pct);

    task automatic send_byte(input logic [7:0] b, input logic fresh);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fresh;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic add_word(input logic [31:0] w);
        frame_q = {frame_q, w[7:0], w[15:8], w[23:16], w[31:24]};
    endtask

    task automatic add_junk(input int n);
        repeat (n)
            frame_q = {frame_q, 8'($urandom)};
    endtask

    // well-formed request from arg_lens, body length off by delta
    task automatic build_request(input int delta);
        int body;
        body = 4;
        foreach (arg_lens[i])
            body += 4 + arg_lens[i];
        frame_q.delete();
        add_word(body + delta);
        add_word(arg_lens.size());
        foreach (arg_lens[i])
        begin
            add_word(arg_lens[i]);
            add_junk(arg_lens[i]);
        end
    endtask

    task automatic send_frame(input logic fresh, input int count);
        for (int i = 0; i < count; i++)
            send_byte(frame_q[i], (i == 0) ? fresh : 1'b0);
        requests++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_MAX_BODY_LEN)
            body_lim = val;
        else
            args_lim = val;
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] body, input logic [CFG_W-1:0] args);
        drain_results();
        write_reg(REG_MAX_BODY_LEN, body);
        write_reg(REG_MAX_ARG_COUNT, args);
    endtask

    task automatic random_traffic(input int target);
        int goal;
        int pick;
        int max_n;
        int n_args;
        int body;
        int len;
        int delta;
        int cut;
        logic [31:0] w;
        goal = good_bytes + target;
        while (good_bytes < goal)
        begin
            pick  = $urandom_range(99);
            max_n = (args_lim < 6) ? args_lim : 6;
            if (args_lim >= 24 && $urandom_range(15) == 0)
                max_n = 24;
            n_args = $urandom_range(max_n, 0);
            arg_lens.delete();
            body = 4;
            for (int i = 0; i < n_args; i++)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 0) : $urandom_range(6, 0);
                if (body + 4 + len > body_lim)
                    break;
                arg_lens = {arg_lens, len};
                body += 4 + len;
            end
            // fill the body up to the limit now and then
            if (arg_lens.size() != 0 && body_lim < 256 && $urandom_range(9) == 0)
            begin
                arg_lens[arg_lens.size() - 1] += body_lim - body;
                body = body_lim;
            end
            if (pick < 75)
            begin
                build_request(0);
                send_frame(need_fresh || ($urandom_range(9) == 0), frame_q.size());
                good_bytes += frame_q.size();
                need_fresh = 1'b0;
            end
            else
            begin
                if (pick < 80)
                begin
                    delta = $urandom_range(3, 1);
                    if ($urandom_range(1) == 0)
                        delta = -delta;
                    build_request(delta);
                    send_frame(need_fresh, frame_q.size());
                end
                else if (pick < 85)
                begin
                    w = ($urandom_range(1) == 0) ? 32'(args_lim + 1) : ($urandom | 32'h1_0000);
                    frame_q.delete();
                    add_word(body_lim);
                    add_word(w);
                    add_junk(3);
                    send_frame(need_fresh, frame_q.size());
                end
                else if (pick < 90)
                begin
                    case ($urandom_range(2))
                        0:       w = 32'(body_lim + 1);
                        1:       w = $urandom | 32'h1_0000;
                        default: w = $urandom_range(3);
                    endcase
                    frame_q.delete();
                    add_word(w);
                    add_junk(2);
                    send_frame(need_fresh, frame_q.size());
                end
                else if (pick < 95)
                begin
                    repeat ($urandom_range(12, 1))
                        send_byte(8'($urandom), 1'($urandom_range(1)));
                end
                else
                begin
                    build_request(0);
                    cut = $urandom_range(frame_q.size() - 1, 1);
                    send_frame(need_fresh, cut);
                end
                need_fresh = 1'b1;
            end
            if ($urandom_range(49) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty request
        frame_q.delete();
        add_word(4);
        add_word(0);
        send_frame(1'b1, frame_q.size());
        // data byte extremes
        frame_q.delete();
        add_word(11);
        add_word(1);
        add_word(3);
        frame_q = {frame_q, 8'h00, 8'hFF, 8'hA5};
        send_frame(1'b0, frame_q.size());
        // empty argument, then a one-byte argument closing the request
        arg_lens = {0, 1};
        build_request(0);
        send_frame(1'b0, frame_q.size());
        // extra body byte after the last argument
        arg_lens = {2};
        build_request(1);
        send_frame(1'b0, frame_q.size());
        // dead stream ignores bytes
        frame_q.delete();
        add_word(4);
        send_frame(1'b0, 3);
        // body length over the limit
        frame_q.delete();
        add_word(4097);
        send_frame(1'b1, frame_q.size());
        // body lengths under four
        frame_q.delete();
        add_word(3);
        send_frame(1'b1, frame_q.size());
        frame_q.delete();
        add_word(0);
        send_frame(1'b1, frame_q.size());
        // argument count over the limit
        frame_q.delete();
        add_word(8);
        add_word(1025);
        send_frame(1'b1, frame_q.size());
        // no room left for the argument header
        frame_q.delete();
        add_word(7);
        add_word(1);
        send_frame(1'b1, frame_q.size());
        // argument length past the end of the body
        frame_q.delete();
        add_word(12);
        add_word(1);
        add_word(5);
        send_frame(1'b1, frame_q.size());
        // body left over with zero arguments
        frame_q.delete();
        add_word(5);
        add_word(0);
        send_frame(1'b1, frame_q.size());
        // restart in the middle of a request
        frame_q.delete();
        add_word(20);
        add_word(2);
        send_frame(1'b1, 5);
        arg_lens = {1};
        build_request(0);
        send_frame(1'b1, frame_q.size());

        random_traffic(110);

        idle_pct = 0;
        set_limits(16'hFFFF, 16'hFFFF);
        random_traffic(190);

        idle_pct = 14;
        set_limits(16'd4, 16'd0);
        random_traffic(70);

        set_limits(16'd40, 16'd3);
        random_traffic(150);

        set_limits(MAX_BODY_LEN_RST, MAX_ARG_COUNT_RST);
        random_traffic(110);

        drain_results();
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes in %0d requests or fragments over five limit settings,",
                 bytes_sent, requests);
        $display("%0d results checked, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lprd_pkg.sv
rtl/core/lprd_parser.sv
rtl/core/lprd_outq.sv
rtl/core/length_prefixed_request_deframer.sv
verif/length_prefixed_request_deframer_checker.sv
verif/length_prefixed_request_deframer_tb.sv
